// File: rtl/core/ple_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the positional list engine.
// No dependencies; the engine and its two interfaces in rtl/core import this package.
package ple_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int WORD_BITS   = 32;

	localparam int ADDR_W = $clog2(MAX_ENTRIES);
	localparam int LEN_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W  = LEN_W + 1;
	localparam int OP_W   = 3;
	localparam int ERR_W  = 2;

	localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_ENTRIES);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_ERASE  = 3'd1,
		OP_GET    = 3'd2,
		OP_SET    = 3'd3,
		OP_STATUS = 3'd4
	} opcode_t;

	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

endpackage

// File: rtl/core/ple_cmd_if.sv
`timescale 1ns / 1ps
// Command channel of the positional list engine: valid/ready plus one command beat.
// Depends on ple_pkg.
interface ple_cmd_if import ple_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [OP_W-1:0]             opcode;
	logic [LEN_W-1:0]            position;
	logic [LEN_W-1:0]            count;
	logic signed [WORD_BITS-1:0] value;

	modport source(output valid, output opcode, output position, output count,
		output value, input ready);
	modport sink(input valid, input opcode, input position, input count,
		input value, output ready);
endinterface

// File: rtl/core/ple_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the positional list engine: valid/ready plus one result beat.
// Depends on ple_pkg.
interface ple_rsp_if import ple_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] read_value;
	logic [LEN_W-1:0]            length;
	logic [CAP_W-1:0]            capacity;
	logic [ERR_W-1:0]            error;

	modport source(output valid, output read_value, output length, output capacity,
		output error, input ready);
	modport sink(input valid, input read_value, input length, input capacity,
		input error, output ready);
endinterface

// File: rtl/core/positional_list_engine.sv
`timescale 1ns / 1ps
// Positional list engine: ordered list of signed words in a single RAM (ple_ram).
// One command at a time; the next is accepted after the result is registered.
// Insert and erase move L - pos and L - pos - n entries. The result waits in an output
// register. Reset: length 0, capacity 1, no beat pending; RAM not cleared.
module positional_list_engine import ple_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ple_cmd_if.sink   cmd,
	ple_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_INS,
		S_ERA,
		S_GET,
		S_DONE
	} state_t;

	state_t state_q;

	logic [OP_W-1:0]      op_q;
	logic [LEN_W-1:0]     pos_q;
	logic [LEN_W-1:0]     cnt_q;
	logic [WORD_BITS-1:0] val_q;

	logic [LEN_W-1:0] len_q;
	logic [CAP_W-1:0] cap_q;
	logic [LEN_W-1:0] ptr_q;
	logic [LEN_W-1:0] num_q;
	logic [ERR_W-1:0] err_q;
	logic [WORD_BITS-1:0] rd_val_q;

	logic              wr_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	logic                 rsp_valid_q;
	logic [WORD_BITS-1:0] rsp_val_q;
	logic [LEN_W-1:0]     rsp_len_q;
	logic [CAP_W-1:0]     rsp_cap_q;
	logic [ERR_W-1:0]     rsp_err_q;

	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic             pos_in_list;
	logic [LEN_W:0]   era_src;
	logic             era_more;
	logic             ins_more;
	logic [LEN_W-1:0] tail;
	logic [CAP_W-1:0] len_inc;

	assign pos_in_list = pos_q < len_q;
	assign era_src     = {1'b0, ptr_q} + {1'b0, num_q};
	assign era_more    = era_src < {1'b0, len_q};
	assign ins_more    = ptr_q > pos_q;
	assign tail        = len_q - pos_q;
	assign len_inc     = {1'b0, len_q} + CAP_W'(1);

	ple_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Moves read one cycle, write the next; the move write owns the port when pending.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = pos_q[ADDR_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = wr_addr_s1;
		ram_wdata = ram_rdata;
		if (wr_s1) begin
			ram_we = 1'b1;
		end else if (state_q == S_INS && !ins_more) begin
			ram_we    = 1'b1;
			ram_waddr = pos_q[ADDR_W-1:0];
			ram_wdata = val_q;
		end else if (state_q == S_EXEC && opcode_t'(op_q) == OP_SET && pos_in_list) begin
			ram_we    = 1'b1;
			ram_waddr = pos_q[ADDR_W-1:0];
			ram_wdata = val_q;
		end
		unique case (state_q)
			S_INS: begin
				ram_re    = ins_more;
				ram_raddr = ADDR_W'(ptr_q - LEN_W'(1));
			end
			S_ERA: begin
				ram_re    = era_more;
				ram_raddr = era_src[ADDR_W-1:0];
			end
			S_EXEC: begin
				ram_re = opcode_t'(op_q) == OP_GET && pos_in_list;
			end
			default: begin
			end
		endcase
	end

	assign cmd.ready      = state_q == S_IDLE;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_val_q;
	assign rsp.length     = rsp_len_q;
	assign rsp.capacity   = rsp_cap_q;
	assign rsp.error      = rsp_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			cap_q       <= CAP_W'(1);
			wr_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			wr_s1 <= 1'b0;
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q     <= cmd.opcode;
						pos_q    <= cmd.position;
						cnt_q    <= cmd.count;
						val_q    <= cmd.value;
						err_q    <= ERR_OK;
						rd_val_q <= '0;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (opcode_t'(op_q))
						OP_INSERT: begin
							if (len_q == LEN_FULL) begin
								err_q <= ERR_FULL;
							end else if (pos_q > len_q) begin
								err_q <= ERR_RANGE;
							end else begin
								ptr_q   <= len_q;
								state_q <= S_INS;
							end
						end
						OP_ERASE: begin
							if (!pos_in_list || cnt_q == '0) begin
								err_q <= ERR_RANGE;
							end else begin
								// clamp the range to the end of the list
								num_q   <= (cnt_q < tail) ? cnt_q : tail;
								ptr_q   <= pos_q;
								state_q <= S_ERA;
							end
						end
						OP_GET: begin
							if (pos_in_list) begin
								state_q <= S_GET;
							end else begin
								err_q <= ERR_RANGE;
							end
						end
						OP_SET: begin
							if (!pos_in_list) begin
								err_q <= ERR_RANGE;
							end
						end
						default: begin
						end
					endcase
				end
				S_INS: begin
					if (ins_more) begin
						wr_s1      <= 1'b1;
						wr_addr_s1 <= ptr_q[ADDR_W-1:0];
						ptr_q      <= ptr_q - LEN_W'(1);
					end else if (!wr_s1) begin
						len_q <= len_inc[LEN_W-1:0];
						if (len_inc >= cap_q) begin
							cap_q <= {cap_q[CAP_W-2:0], 1'b0};
						end
						state_q <= S_DONE;
					end
				end
				S_ERA: begin
					if (era_more) begin
						wr_s1      <= 1'b1;
						wr_addr_s1 <= ptr_q[ADDR_W-1:0];
						ptr_q      <= ptr_q + LEN_W'(1);
					end else if (!wr_s1) begin
						len_q   <= len_q - num_q;
						state_q <= S_DONE;
					end
				end
				S_GET: begin
					rd_val_q <= ram_rdata;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_val_q   <= rd_val_q;
						rsp_len_q   <= len_q;
						rsp_cap_q   <= cap_q;
						rsp_err_q   <= err_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/ple_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for positional_list_engine: random and directed list commands, a shadow list
// that predicts every response beat, and a scoreboard that checks them in order.
// Depends on ple_pkg, ple_cmd_if, ple_rsp_if and the engine RTL.
module tb;
	import ple_pkg::*;

	localparam int CYCLE_LIMIT = 8_000_000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [OP_W-1:0]             opcode;
		logic [LEN_W-1:0]            position;
		logic [LEN_W-1:0]            count;
		logic signed [WORD_BITS-1:0] value;
	} cmd_beat_t;

	typedef struct {
		logic signed [WORD_BITS-1:0] read_value;
		logic [LEN_W-1:0]            length;
		logic [CAP_W-1:0]            capacity;
		logic [ERR_W-1:0]            error;
	} rsp_beat_t;

	// Shadow copy of the list plus the queue of responses still owed by the engine.
	class list_tracker;
		logic signed [WORD_BITS-1:0] entries [MAX_ENTRIES];
		int list_len;
		int list_cap;
		int errors;
		rsp_beat_t owed_rsp [$];

		function new();
			list_len = 0;
			list_cap = 1;
			errors = 0;
		endfunction

		function rsp_beat_t apply_list_op(cmd_beat_t c);
			rsp_beat_t r;
			int p;
			int n;
			p = int'(c.position);
			r.read_value = '0;
			r.error = ERR_OK;
			case (c.opcode)
				OP_INSERT: begin
					if (list_len >= MAX_ENTRIES) begin
						r.error = ERR_FULL;
					end else if (p > list_len) begin
						r.error = ERR_RANGE;
					end else begin
						for (int i = list_len; i > p; i--)
							entries[i] = entries[i-1];
						entries[p] = c.value;
						list_len++;
						while (list_len >= list_cap)
							list_cap *= 2;
					end
				end
				OP_ERASE: begin
					if (p >= list_len || c.count == 0) begin
						r.error = ERR_RANGE;
					end else begin
						// range clamps at the tail
						n = list_len - p;
						if (int'(c.count) < n)
							n = int'(c.count);
						for (int i = p; i + n < list_len; i++)
							entries[i] = entries[i+n];
						list_len -= n;
					end
				end
				OP_GET: begin
					if (p < list_len)
						r.read_value = entries[p];
					else
						r.error = ERR_RANGE;
				end
				OP_SET: begin
					if (p < list_len)
						entries[p] = c.value;
					else
						r.error = ERR_RANGE;
				end
				default: ; // status and spare opcodes change nothing
			endcase
			r.length = LEN_W'(list_len);
			r.capacity = CAP_W'(list_cap);
			return r;
		endfunction

		function void note_command(cmd_beat_t c);
			owed_rsp.push_back(apply_list_op(c));
		endfunction

		function int outstanding();
			return owed_rsp.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 200)
				$display("MISMATCH @%0t: %s", $realtime, msg);
		endtask

		task check_response(rsp_beat_t got);
			rsp_beat_t want;
			if (owed_rsp.size() == 0) begin
				report($sformatf("response beat with none owed (length %0d)", got.length));
				return;
			end
			want = owed_rsp.pop_front();
			if (got.read_value !== want.read_value)
				report($sformatf("read_value %0d, want %0d", got.read_value, want.read_value));
			if (got.length !== want.length)
				report($sformatf("length %0d, want %0d", got.length, want.length));
			if (got.capacity !== want.capacity)
				report($sformatf("capacity %0d, want %0d", got.capacity, want.capacity));
			if (got.error !== want.error)
				report($sformatf("error %0d, want %0d", got.error, want.error));
		endtask
	endclass

	logic clk;
	logic arst_n;

	ple_cmd_if cmd_ch ();
	ple_rsp_if rsp_ch ();

	positional_list_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	list_tracker sb = new();

	int send_idle = 17;
	int recv_idle = 68;
	int hold_req = 0;
	int cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Response side: random back-pressure, or a long hold when requested.
	initial begin : rsp_driver
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	always @(posedge clk) begin : rsp_monitor
		rsp_beat_t got;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.read_value = rsp_ch.read_value;
			got.length = rsp_ch.length;
			got.capacity = rsp_ch.capacity;
			got.error = rsp_ch.error;
			sb.check_response(got);
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("positional_list_engine test failed");
		$finish;
	end

	function automatic cmd_beat_t beat_of(logic [OP_W-1:0] op, int pos, int cnt,
		logic signed [WORD_BITS-1:0] val);
		cmd_beat_t c;
		c.opcode = op;
		c.position = LEN_W'(pos);
		c.count = LEN_W'(cnt);
		c.value = val;
		return c;
	endfunction

	function automatic logic signed [WORD_BITS-1:0] rand_word();
		case ($urandom_range(9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// slack 1 for insert (position len is legal), 0 for erase/get/set
	function automatic logic [LEN_W-1:0] rand_pos(int len, int slack);
		int top;
		top = len - 1 + slack;
		if (top < 0)
			top = 0;
		case ($urandom_range(19))
			0: return LEN_W'($urandom);
			1: return LEN_W'(len + slack);
			2, 3, 4: return LEN_W'(top);
			default: return LEN_W'($urandom_range(0, top));
		endcase
	endfunction

	function automatic cmd_beat_t rand_cmd(int target);
		cmd_beat_t c;
		int len;
		int roll;
		int ins_w;
		len = sb.list_len;
		c.value = rand_word();
		c.count = LEN_W'($urandom_range(1, 6));
		c.position = '0;
		ins_w = (len < target) ? 45 : 20;
		roll = $urandom_range(99);
		if (roll < 4) begin
			c.opcode = OP_W'($urandom);
			c.position = LEN_W'($urandom);
			c.count = LEN_W'($urandom);
		end else if (roll < 4 + ins_w) begin
			c.opcode = OP_INSERT;
			c.position = rand_pos(len, 1);
		end else if (roll < 69) begin
			c.opcode = OP_ERASE;
			c.position = rand_pos(len, 0);
			case ($urandom_range(9))
				0: c.count = '0;
				1: c.count = LEN_W'($urandom);
				2: c.count = LEN_W'(len - int'(c.position));
				default: ;
			endcase
		end else if (roll < 83) begin
			c.opcode = OP_GET;
			c.position = rand_pos(len, 0);
		end else if (roll < 95) begin
			c.opcode = OP_SET;
			c.position = rand_pos(len, 0);
		end else begin
			c.opcode = OP_STATUS;
			c.position = LEN_W'($urandom);
		end
		return c;
	endfunction

	// Called in a posedge time step; returns in the step of the accepting edge.
	task automatic send_beat(cmd_beat_t c);
		if ($urandom_range(99) < send_idle) begin
			cmd_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= c.opcode;
		cmd_ch.position <= c.position;
		cmd_ch.count <= c.count;
		cmd_ch.value <= c.value;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		sb.note_command(c);
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	task automatic run_random(int n, int target);
		repeat (n) send_beat(rand_cmd(target));
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.opcode <= '0;
		cmd_ch.position <= '0;
		cmd_ch.count <= '0;
		cmd_ch.value <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, edge positions, word extremes, clamping
		send_beat(beat_of(OP_STATUS, 0, 0, 0));
		send_beat(beat_of(OP_GET, 0, 0, 0));
		send_beat(beat_of(OP_SET, 0, 0, 32'sh1234_5678));
		send_beat(beat_of(OP_ERASE, 0, 1, 0));
		send_beat(beat_of(OP_INSERT, 1, 0, -1));
		send_beat(beat_of(OP_INSERT, 0, 0, 32'sh7FFF_FFFF));
		send_beat(beat_of(OP_INSERT, 0, 0, 32'sh8000_0000));
		send_beat(beat_of(OP_INSERT, 2, 0, -1));
		send_beat(beat_of(OP_INSERT, 1, 0, 0));
		send_beat(beat_of(OP_INSERT, 4, 0, 1));
		for (int k = 0; k <= 5; k++)
			send_beat(beat_of(OP_GET, k, 0, 0));
		send_beat(beat_of(OP_SET, 1, 0, 32'sh5555_5555));
		send_beat(beat_of(OP_SET, 5, 0, 32'shAAAA_AAAA));
		send_beat(beat_of(OP_ERASE, 0, 0, 0));
		send_beat(beat_of(OP_ERASE, 5, 1, 0));
		send_beat(beat_of(OP_ERASE, 1, 2047, 0));
		for (int k = OP_STATUS + 1; k < 2 ** OP_W; k++)
			send_beat(beat_of(OP_W'(k), 2047, 2047, $urandom));
		send_beat(beat_of(OP_INSERT, 2047, 0, 0));
		send_beat(beat_of(OP_ERASE, 2047, 2047, 0));

		// sender light, receiver heavy; includes a long receiver hold
		run_random(80, 40);
		send_idle = 0;
		hold_req = 300;
		run_random(12, 40);
		send_idle = 17;
		drain();
		run_random(80, 40);

		send_idle = 68;
		recv_idle = 17;
		run_random(200, 80);
		drain();

		send_idle = 0;
		recv_idle = 0;
		// grow the list, mostly by appends
		while (sb.list_len < 160) begin
			if ($urandom_range(9) == 0)
				send_beat(beat_of($urandom_range(1) ? OP_GET : OP_SET,
					$urandom_range(0, sb.list_len), 0, rand_word()));
			else
				send_beat(beat_of(OP_INSERT, sb.list_len, 0, rand_word()));
		end
		send_beat(beat_of(OP_INSERT, 0, 0, 1));
		send_beat(beat_of(OP_INSERT, sb.list_len + 1, 0, 2));
		send_beat(beat_of(OP_INSERT, 2047, 0, 3));
		send_beat(beat_of(OP_STATUS, 0, 0, 0));
		send_beat(beat_of(OP_GET, sb.list_len - 1, 0, 0));
		send_beat(beat_of(OP_GET, sb.list_len, 0, 0));
		send_beat(beat_of(OP_SET, sb.list_len - 1, 0, 32'sh8000_0000));
		send_beat(beat_of(OP_ERASE, sb.list_len - 1, 1, 0));
		send_beat(beat_of(OP_INSERT, sb.list_len - 1, 0, 32'sh7FFF_FFFF));
		send_beat(beat_of(OP_ERASE, 0, 1, 0));
		send_beat(beat_of(OP_INSERT, 0, 0, -1));
		send_beat(beat_of(OP_GET, 0, 0, 0));
		send_beat(beat_of(OP_ERASE, $urandom_range(16, 48), 2047, 0));
		run_random(80, 40);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("positional_list_engine test passed");
		else
			$display("positional_list_engine test failed");
		$finish;
	end

endmodule
